[rtl/cphm_pkg.sv]
// Shared sizes, codes and controller/datapath interface types for the codepoint hash map.
package cphm_pkg;

    localparam int MAX_ENTRIES  = 512;
    localparam int TABLE_SLOTS  = 1024;
    localparam int DIRECT_RANGE = 256;

    localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = ENTRY_W + 1;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int SLOT_DATA_W = ENTRY_W + 1;
    localparam int DIRECT_W    = (DIRECT_RANGE > 1) ? $clog2(DIRECT_RANGE) : 1;

    localparam int CP_W      = 21;
    localparam int WORD_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int IDX_OUT_W = 9;
    localparam int HASH_W    = 32;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [HASH_W-1:0] MIX_MUL_B = 32'h846ca68b;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic probe_init;
        logic slot_rd;
        logic entry_rd;
        logic probe_step;
        logic set_match;
        logic set_empty;
        logic finish;
    } cphm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic slot_valid;
        logic slot_live;
        logic key_eq;
        logic probe_last;
        logic direct_skip;
        logic out_free;
    } cphm_stat_t;

endpackage

[rtl/cphm_hash.sv]
// Two-stage registered xor-shift-multiply mixer that yields the home slot of a codepoint.
module cphm_hash
    import cphm_pkg::*;
(
    input  logic              clk,
    input  logic [CP_W-1:0]   key,
    output logic [SLOT_W-1:0] home
);

    logic [HASH_W-1:0] mul1_reg;
    logic [HASH_W-1:0] mul2_reg;
    logic [HASH_W-1:0] key_ext;
    logic [HASH_W-1:0] mix_a;
    logic [HASH_W-1:0] mix_b;
    logic [HASH_W-1:0] mix_c;
    logic [HASH_W-1:0] mul1_next;
    logic [HASH_W-1:0] mul2_next;

    always_comb
    begin
        key_ext   = HASH_W'(key);
        mix_a     = key_ext ^ (key_ext >> 16);
        mul1_next = mix_a * MIX_MUL_A;
        mix_b     = mul1_reg ^ (mul1_reg >> 15);
        mul2_next = mix_b * MIX_MUL_B;
        mix_c     = mul2_reg ^ (mul2_reg >> 16);
        home      = mix_c[SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        mul1_reg <= mul1_next;
        mul2_reg <= mul2_next;
    end

endmodule

[rtl/cphm_dpath.sv]
// Datapath: request registers, slot table, entry store, direct store and result register.
module cphm_dpath
    import cphm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cphm_cmd_t            cmd,
    output cphm_stat_t           stat,
    input  logic                 in_req_type,
    input  logic [CP_W-1:0]      in_codepoint,
    input  logic [WORD_W-1:0]    in_glyph_word,
    input  logic                 in_glyph_present,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  out_status,
    output logic [IDX_OUT_W-1:0] out_entry_index,
    output logic [WORD_W-1:0]    out_found_word
);

    logic                    req_type_reg;
    logic [CP_W-1:0]         req_cp_reg;
    logic [WORD_W-1:0]       req_word_reg;
    logic                    req_present_reg;

    logic [SLOT_W-1:0]       clr_reg;
    logic [SLOT_W-1:0]       probe_slot_reg;
    logic [SLOT_W-1:0]       probe_cnt_reg;
    logic                    match_reg;
    logic                    empty_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [DIRECT_RANGE-1:0] present_reg;

    logic [SLOT_DATA_W-1:0]  slot_mem [TABLE_SLOTS];
    logic [SLOT_DATA_W-1:0]  slot_q;
    logic [CP_W-1:0]         ekey_mem [MAX_ENTRIES];
    logic [WORD_W-1:0]       eword_mem [MAX_ENTRIES];
    logic [CP_W-1:0]         ekey_q;
    logic [WORD_W-1:0]       eword_q;
    logic [WORD_W-1:0]       dword_mem [DIRECT_RANGE];
    logic [WORD_W-1:0]       dword_q;

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [IDX_OUT_W-1:0]    out_idx_reg;
    logic [WORD_W-1:0]       out_word_reg;

    logic [SLOT_W-1:0]       home;
    logic [DIRECT_W-1:0]     direct_idx;
    logic [ENTRY_W-1:0]      slot_entry;
    logic [ENTRY_W-1:0]      new_entry;
    logic [ENTRY_W-1:0]      word_addr;
    logic                    in_range;
    logic                    present_bit;
    logic                    count_full;
    logic                    do_append;
    logic                    do_update;
    logic                    do_direct;
    logic [STATUS_W-1:0]     res_status;
    logic [ENTRY_W-1:0]      res_idx;
    logic [WORD_W-1:0]       res_word;

    cphm_hash u_hash
    (
        .clk  (clk),
        .key  (req_cp_reg),
        .home (home)
    );

    always_comb
    begin
        direct_idx  = req_cp_reg[DIRECT_W-1:0];
        slot_entry  = slot_q[ENTRY_W-1:0];
        new_entry   = count_reg[ENTRY_W-1:0];
        in_range    = req_cp_reg < CP_W'(DIRECT_RANGE);
        present_bit = in_range && present_reg[direct_idx];
        count_full  = count_reg >= COUNT_W'(MAX_ENTRIES);

        stat.clear_last  = clr_reg == SLOT_W'(TABLE_SLOTS - 1);
        stat.slot_valid  = slot_q[ENTRY_W];
        stat.slot_live   = slot_q[ENTRY_W] && ({1'b0, slot_entry} < count_reg);
        stat.key_eq      = ekey_q == req_cp_reg;
        stat.probe_last  = probe_cnt_reg == SLOT_W'(TABLE_SLOTS - 1);
        stat.direct_skip = (req_type_reg == REQ_LOOKUP) && in_range && !present_bit;
        stat.out_free    = !out_valid_reg || out_ready;

        res_status = ST_MISS;
        res_idx    = '0;
        res_word   = '0;
        do_append  = 1'b0;
        do_update  = 1'b0;
        if (req_type_reg == REQ_INSERT)
        begin
            if (match_reg)
            begin
                res_status = ST_OK;
                res_idx    = slot_entry;
                do_update  = 1'b1;
            end
            else if (!empty_reg || count_full)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                res_status = ST_NEW;
                res_idx    = new_entry;
                do_append  = 1'b1;
            end
        end
        else if (in_range)
        begin
            if (present_bit)
            begin
                res_status = ST_OK;
                res_word   = dword_q;
                if (match_reg)
                begin
                    res_idx = slot_entry;
                end
            end
        end
        else if (match_reg)
        begin
            res_status = ST_OK;
            res_idx    = slot_entry;
            res_word   = eword_q;
        end

        do_direct = (req_type_reg == REQ_INSERT) && in_range;
        word_addr = do_append ? new_entry : slot_entry;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_cp_reg      <= in_codepoint;
            req_word_reg    <= in_glyph_word;
            req_present_reg <= in_glyph_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_type_reg   <= REQ_INSERT;
            clr_reg        <= '0;
            probe_slot_reg <= '0;
            probe_cnt_reg  <= '0;
            match_reg      <= 1'b0;
            empty_reg      <= 1'b0;
            count_reg      <= '0;
            present_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                req_type_reg <= in_req_type;
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.probe_init)
            begin
                probe_slot_reg <= home;
                probe_cnt_reg  <= '0;
                match_reg      <= 1'b0;
                empty_reg      <= 1'b0;
            end
            else if (cmd.probe_step)
            begin
                probe_slot_reg <= probe_slot_reg + SLOT_W'(1);
                probe_cnt_reg  <= probe_cnt_reg + SLOT_W'(1);
            end
            if (cmd.set_match)
            begin
                match_reg <= 1'b1;
            end
            if (cmd.set_empty)
            begin
                empty_reg <= 1'b1;
            end
            if (cmd.finish && do_append)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.finish && do_direct)
            begin
                present_reg[direct_idx] <= req_present_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            slot_mem[clr_reg] <= '0;
        end
        else if (cmd.finish && do_append)
        begin
            slot_mem[probe_slot_reg] <= {1'b1, new_entry};
        end
        if (cmd.slot_rd)
        begin
            slot_q <= slot_mem[probe_slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_append)
        begin
            ekey_mem[new_entry] <= req_cp_reg;
        end
        if (cmd.entry_rd)
        begin
            ekey_q <= ekey_mem[slot_entry];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && (do_append || do_update))
        begin
            eword_mem[word_addr] <= req_word_reg;
        end
        if (cmd.entry_rd)
        begin
            eword_q <= eword_mem[slot_entry];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_direct)
        begin
            dword_mem[direct_idx] <= req_word_reg;
        end
        dword_q <= dword_mem[direct_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= res_status;
            out_idx_reg    <= IDX_OUT_W'(res_idx);
            out_word_reg   <= res_word;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_entry_index = out_idx_reg;
    assign out_found_word  = out_word_reg;

endmodule

[rtl/cphm_ctrl.sv]
// Controller state machine: slot table clearing, hashing, probe walk and result hand-off.
module cphm_ctrl
    import cphm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cphm_stat_t stat,
    output cphm_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH1 = 4'd2;
    localparam logic [3:0] S_HASH2 = 4'd3;
    localparam logic [3:0] S_HOME  = 4'd4;
    localparam logic [3:0] S_SRD   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_HASH1;
                end
            end
            S_HASH1:
            begin
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                state_next = S_HOME;
            end
            S_HOME:
            begin
                cmd.probe_init = 1'b1;
                state_next     = stat.direct_skip ? S_FIN : S_SRD;
            end
            S_SRD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_ERD;
            end
            S_ERD:
            begin
                if (!stat.slot_valid)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_FIN;
                end
                else if (stat.slot_live)
                begin
                    cmd.entry_rd = 1'b1;
                    state_next   = S_CMP;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                    state_next     = stat.probe_last ? S_FIN : S_SRD;
                end
            end
            S_CMP:
            begin
                if (stat.key_eq)
                begin
                    cmd.set_match = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                    state_next     = stat.probe_last ? S_FIN : S_SRD;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/codepoint_hash_map_linear_probe.sv]
// Top level of the codepoint-keyed glyph store with a linearly probed slot table.
//
// Channel  Dir  Handshake                      Contents
// s_axis   in   s_axis_tvalid / s_axis_tready  request item: kind, codepoint, glyph record
// m_axis   out  m_axis_tvalid / m_axis_tready  result item: status, entry index, record
//
// An item passes through accept, two hash multiply stages and home slot set-up before the
// first slot probe; each slot visited is read, a slot with a live entry then has its entry
// read and its key compared, and an empty slot ends the walk; a final step writes back and
// loads the result register. A direct-range lookup of an absent record skips the walk.
// The probe loop runs over the single-ported slot and entry memories.
// After reset the slot table is cleared one slot a cycle, with s_axis_tready low.
// A held result stalls only the write-back; the next item is accepted once it is loaded.
module codepoint_hash_map_linear_probe
    import cphm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // codepoint, glyph_word, glyph_present, zero pad
    input  logic [0:0]           s_axis_tuser,  // req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // entry_index, found_word, zero pad
    output logic [STATUS_W-1:0]  m_axis_tuser   // status
);

    cphm_cmd_t            cmd;
    cphm_stat_t           stat;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [WORD_W-1:0]    found_word;

    cphm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cphm_dpath u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_req_type      (s_axis_tuser[0]),
        .in_codepoint     (s_axis_tdata[CP_W-1:0]),
        .in_glyph_word    (s_axis_tdata[CP_W+WORD_W-1:CP_W]),
        .in_glyph_present (s_axis_tdata[CP_W+WORD_W]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (m_axis_tuser),
        .out_entry_index  (entry_index),
        .out_found_word   (found_word)
    );

    assign m_axis_tdata = M_TDATA_W'({found_word, entry_index});

    assert property (@(posedge clk) disable iff (!rst_n) cmd.clear_wr |-> !s_axis_tready)
        else $error("item accepted while the slot table is being cleared");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> stat.out_free)
        else $error("result loaded over one that was not taken");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.entry_rd |-> stat.slot_live)
        else $error("entry read through a slot that holds no live entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.set_match, cmd.set_empty, cmd.accept, cmd.finish}))
        else $error("conflicting controller commands");

endmodule
